>>> hdl/rmb_pkg.sv
// ----------------------------------------------------------------------------
// rmb_pkg: shared types and constants
// Payload structs and binary64 field constants for the mean-to-binary64 unit.
// ----------------------------------------------------------------------------
package rmb_pkg;

   localparam int unsigned SIG_BITS   = 53;
   localparam int unsigned FRAC_BITS  = 52;
   localparam int unsigned EXP_BITS   = 11;
   localparam int unsigned EXP_BIAS   = 1023;
   localparam int unsigned QUOT_LOG2  = 16;   // quotient limit is 2**16
   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned WIDE_BITS  = WORD_BITS + QUOT_LOG2;

   typedef struct packed {
      logic signed [63:0] total;
      logic signed [63:0] count;
   } req_type;

   typedef struct packed {
      logic [63:0] mean_bits;
      logic        status;
   } rsp_type;

   typedef enum logic {
      STATUS_OK      = 1'b0,
      STATUS_INVALID = 1'b1
   } status_type;

   typedef struct packed {
      logic ge;
      logic eq;
   } cmp_type;

endpackage

>>> hdl/rmb_divstep.sv
// ----------------------------------------------------------------------------
// rmb_divstep: shared compare/subtract unit
// One restoring-division step: compares a against b and forms a - b.
// ----------------------------------------------------------------------------
module rmb_divstep (
   input  logic [rmb_pkg::WIDE_BITS-1:0] a,
   input  logic [rmb_pkg::WIDE_BITS-1:0] b,
   output rmb_pkg::cmp_type              cmp,
   output logic [rmb_pkg::WIDE_BITS-1:0] diff
);
   import rmb_pkg::*;

   logic [WIDE_BITS:0] sub;

   assign sub      = {1'b0, a} - {1'b0, b};
   assign diff     = sub[WIDE_BITS-1:0];
   assign cmp.ge   = ~sub[WIDE_BITS];
   assign cmp.eq   = (a == b);

endmodule

>>> hdl/rounded_mean_to_binary64_unit.sv
// ----------------------------------------------------------------------------
// rounded_mean_to_binary64_unit: total/count as correctly rounded binary64
// Iterative restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries {total, count}; rsp channel carries
//   {mean_bits, status}. One response per request, in order.
//   The quotient is produced one bit per cycle through a single shared
//   80-bit compare/subtract unit: 17 integer steps (weights 2^16..2^0, the
//   top one only detects overflow), then fraction steps until 53
//   significand bits exist, then a rounding state and an output state.
//   Invalid arguments and zero total skip the division and go straight to
//   the output state; quotient overflow ends the run at the top integer
//   step. req_ready is high only while the sequencer is idle; the next req
//   is taken the cycle after the result is loaded, so the unit does not
//   take a new request until the last result is in the output register.
//   The result sits in an output register; a stalled receiver holds it
//   there, and the next item may already be computing.
//   Synchronous reset returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module rounded_mean_to_binary64_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmb_pkg::rsp_type rsp_data
);
   import rmb_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_ROUND,
      S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [63:0]        rem_ff, rem_in;
   logic [63:0]        div_ff, div_in;
   logic [4:0]         step_ff, step_in;
   logic               int_ff, int_in;
   logic               found_ff, found_in;
   logic [5:0]         nbits_ff, nbits_in;
   logic signed [7:0]  weight_ff, weight_in;
   logic signed [7:0]  expo_ff, expo_in;
   logic [SIG_BITS-1:0] sig_ff, sig_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [WIDE_BITS-1:0] unit_a, unit_b, unit_diff;
   cmp_type              unit_cmp;
   logic                 bit_q, rnd_up;
   logic [SIG_BITS:0]    sum;
   logic signed [7:0]    expo_fin;
   logic [EXP_BITS-1:0]  biased;

   rmb_divstep u_divstep (
      .a    (unit_a),
      .b    (unit_b),
      .cmp  (unit_cmp),
      .diff (unit_diff)
   );

   // integer phase: r vs count<<i; fraction and rounding: 2r vs count
   always_comb begin
      if (state_ff == S_RUN && int_ff) begin
         unit_a = {{QUOT_LOG2{1'b0}}, rem_ff};
         unit_b = {{QUOT_LOG2{1'b0}}, div_ff} << step_ff;
      end else begin
         unit_a = {{(QUOT_LOG2-1){1'b0}}, rem_ff, 1'b0};
         unit_b = {{QUOT_LOG2{1'b0}}, div_ff};
      end
   end

   assign bit_q    = unit_cmp.ge;
   assign rnd_up   = (unit_cmp.ge && !unit_cmp.eq) || (unit_cmp.eq && sig_ff[0]);
   assign sum      = {1'b0, sig_ff} + {{SIG_BITS{1'b0}}, rnd_up};
   assign expo_fin = sum[SIG_BITS] ? expo_ff + 8'sd1 : expo_ff;
   assign biased   = EXP_BITS'(EXP_BIAS) + EXP_BITS'(expo_fin);

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      int_in       = int_ff;
      found_in     = found_ff;
      nbits_in     = nbits_ff;
      weight_in    = weight_ff;
      expo_in      = expo_ff;
      sig_in       = sig_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rem_in    = req_data.total;
               div_in    = req_data.count;
               step_in   = 5'(QUOT_LOG2);
               int_in    = 1'b1;
               found_in  = 1'b0;
               nbits_in  = '0;
               weight_in = 8'(QUOT_LOG2);
               sig_in    = '0;
               res_in    = '0;
               if (req_data.total < 0 || req_data.count <= 0) begin
                  res_in.status = STATUS_INVALID;
                  state_in      = S_OUT;
               end else if (req_data.total == 0) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            rem_in    = bit_q ? unit_diff[63:0] : unit_a[63:0];
            weight_in = weight_ff - 8'sd1;
            if (int_ff) begin
               if (step_ff == '0) int_in  = 1'b0;
               else               step_in = step_ff - 5'd1;
            end
            if (int_ff && step_ff == 5'(QUOT_LOG2) && bit_q) begin
               res_in.status = STATUS_INVALID;
               state_in      = S_OUT;
            end else if (found_ff || bit_q) begin
               sig_in   = {sig_ff[SIG_BITS-2:0], bit_q};
               nbits_in = nbits_ff + 6'd1;
               if (!found_ff) begin
                  found_in = 1'b1;
                  expo_in  = weight_ff;
               end
               if (nbits_ff == 6'(SIG_BITS - 1)) state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            res_in.status    = STATUS_OK;
            res_in.mean_bits = {1'b0, biased,
                                sum[SIG_BITS] ? {FRAC_BITS{1'b0}} : sum[FRAC_BITS-1:0]};
            state_in         = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      step_ff     <= step_in;
      int_ff      <= int_in;
      found_ff    <= found_in;
      nbits_ff    <= nbits_in;
      weight_ff   <= weight_in;
      expo_ff     <= expo_in;
      sig_ff      <= sig_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/rmb_checker.sv
// ----------------------------------------------------------------------------
// rmb_checker: port-level checks for the mean-to-binary64 unit
// Watches the top level's channels; bound to every instance.
// ----------------------------------------------------------------------------
module rmb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rmb_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rmb_pkg::rsp_type rsp_data
);
   import rmb_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req changed while waiting");

   // one item at a time: busy right after a transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after transfer");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.mean_bits == '0)
      else $error("invalid response with nonzero bits");

   // valid nonzero results are positive normals in [2^-63, 2^16]
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.status && rsp_data.mean_bits != '0 |->
      !rsp_data.mean_bits[63] && rsp_data.mean_bits[62:52] >= 11'(EXP_BIAS - 63)
      && rsp_data.mean_bits[62:52] <= 11'(EXP_BIAS + 16))
      else $error("result exponent out of range");

endmodule

bind rounded_mean_to_binary64_unit rmb_checker u_rmb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
